@@ hw/rtl/tsi_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsi_pkg
// types and constants shared by the transmit safety interlock modules
// ----------------------------------------------------------------------------
package tsi_pkg;

  localparam int unsigned HistDepthDef = 64;

  localparam int unsigned TimeW   = 48;
  localparam int unsigned WidthW  = 24;
  localparam int unsigned PowerW  = 12;
  localparam int unsigned AttW    = 10;
  localparam int unsigned PressW  = 15;
  localparam int unsigned SrcW    = 5;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 15;
  localparam int unsigned InDataW  = 160;
  localparam int unsigned OutDataW = 8;
  // doubled times with sign
  localparam int unsigned T2W = TimeW + 3;

  typedef enum logic [1:0] {
    REQ_HV     = 2'd0,
    REQ_MODE   = 2'd1,
    REQ_REPORT = 2'd2,
    REQ_HEALTH = 2'd3
  } req_type_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_SWITCH_ATT = 2'd1,
    CFG_RELEASE   = 2'd2,
    CFG_MIN_PRESS = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_ALLOWED     = 4'd0,
    ST_ATTENUATE   = 4'd1,
    ST_SRC_IO      = 4'd2,
    ST_SRC_NAV     = 4'd3,
    ST_SRC_TERRAIN = 4'd4,
    ST_SRC_MOTION  = 4'd5,
    ST_SRC_PWRSRV  = 4'd6,
    ST_FILAMENT    = 4'd7,
    ST_HOMING      = 4'd8,
    ST_PRESSURE    = 4'd9,
    ST_POWER       = 4'd10,
    ST_NO_ATTEN    = 4'd11,
    ST_UNSET       = 4'd12
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_WALK = 2'd1,
    S_EVAL = 2'd2
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic walk_step;
    logic commit;
  } tsi_cmd_t;

  typedef struct packed {
    logic walk_done;
  } tsi_sts_t;

  typedef struct packed {
    logic    hv_forced_off;
    logic    use_attenuated;
    logic    hv_enable;
    status_e status_code;
  } tsi_result_t;

endpackage

@@ hw/rtl/tsi_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsi_ctrl
// sequencer: accepts events, runs the history walk, commits the evaluation
// ----------------------------------------------------------------------------
module tsi_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [1:0]        s_axis_tuser_i,
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output tsi_pkg::tsi_cmd_t cmd_o,
  input  tsi_pkg::tsi_sts_t sts_i
);
  import tsi_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_vld_q, out_vld_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    cmd_o           = '0;
    s_axis_tready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          cmd_o.load = 1'b1;
          unique case (req_type_e'(s_axis_tuser_i))
            REQ_MODE:   state_d = S_IDLE;
            REQ_REPORT: state_d = S_WALK;
            default:    state_d = S_EVAL;
          endcase
        end
      end
      S_WALK: begin
        cmd_o.walk_step = 1'b1;
        if (sts_i.walk_done) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        if (!out_vld_q || m_axis_tready_i) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_vld_q && m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end
    if (cmd_o.commit) begin
      out_vld_d = 1'b1;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;

`ifndef SYNTHESIS
  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> (!out_vld_q || m_axis_tready_i))
    else $error("result overwritten before transfer");
  a_report_walks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load && s_axis_tuser_i == REQ_REPORT) |=> state_q == S_WALK)
    else $error("report did not start history walk");
  a_commit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> out_vld_q)
    else $error("commit without result valid");
`endif

endmodule

@@ hw/rtl/tsi_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsi_dp
// datapath: config, health state, mode history ring, window walk, checks
// ----------------------------------------------------------------------------
module tsi_dp #(
  parameter int unsigned HISTORY_DEPTH = tsi_pkg::HistDepthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tsi_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tsi_pkg::CfgW-1:0]     cfg_wdata_i,
  input  logic [tsi_pkg::InDataW-1:0]  s_axis_tdata_i,
  input  logic [1:0]                   s_axis_tuser_i,
  output logic [tsi_pkg::OutDataW-1:0] m_axis_tdata_o,
  input  tsi_pkg::tsi_cmd_t            cmd_i,
  output tsi_pkg::tsi_sts_t            sts_o
);
  import tsi_pkg::*;

  localparam int unsigned IdxW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(HISTORY_DEPTH + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(HISTORY_DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(HISTORY_DEPTH);

  // input fields
  logic                     in_hv;
  logic [TimeW-1:0]         in_mode_time;
  logic                     in_mode_att;
  logic [TimeW-1:0]         in_center;
  logic [WidthW-1:0]        in_width;
  logic signed [PowerW-1:0] in_power;
  logic [SrcW-1:0]          in_src;
  logic                     in_fil;
  logic                     in_homed;
  logic [PressW-1:0]        in_press;
  logic                     in_avail;
  req_type_e                in_type;

  assign in_hv        = s_axis_tdata_i[0];
  assign in_mode_time = s_axis_tdata_i[48:1];
  assign in_mode_att  = s_axis_tdata_i[49];
  assign in_center    = s_axis_tdata_i[97:50];
  assign in_width     = s_axis_tdata_i[121:98];
  assign in_power     = s_axis_tdata_i[133:122];
  assign in_src       = s_axis_tdata_i[138:134];
  assign in_fil       = s_axis_tdata_i[139];
  assign in_homed     = s_axis_tdata_i[140];
  assign in_press     = s_axis_tdata_i[155:141];
  assign in_avail     = s_axis_tdata_i[156];
  assign in_type      = req_type_e'(s_axis_tuser_i);

  // config
  logic signed [PowerW-1:0] thr_q;
  logic [AttW-1:0]          sw_att_q;
  logic [AttW-1:0]          rel_q;
  logic [PressW-1:0]        min_press_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= -12'sd300;
      sw_att_q    <= '0;
      rel_q       <= AttW'(60);
      min_press_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_THRESHOLD:  thr_q       <= cfg_wdata_i[PowerW-1:0];
        CFG_SWITCH_ATT: sw_att_q    <= cfg_wdata_i[AttW-1:0];
        CFG_RELEASE:    rel_q       <= cfg_wdata_i[AttW-1:0];
        CFG_MIN_PRESS:  min_press_q <= cfg_wdata_i[PressW-1:0];
        default: ;
      endcase
    end
  end

  // interlock state
  logic                     hv_q;
  status_e                  last_q;
  logic [SrcW-1:0]          src_q;
  logic                     fil_q, homed_q, avail_q;
  logic [PressW-1:0]        press_q;
  logic signed [PowerW-1:0] power_q;
  logic                     rep_att_q;

  // history ring
  logic [IdxW-1:0]  head_q;
  logic [CntW-1:0]  cnt_q;
  logic             e0_wr_q;
  logic [TimeW:0]   mem [HISTORY_DEPTH];
  logic [TimeW:0]   rd_data_q;
  logic [IdxW-1:0]  wr_idx;
  logic             hist_we;

  // walk
  logic signed [T2W-1:0] start2_q, end2_q;
  logic [IdxW-1:0]       ptr_q;
  logic [CntW-1:0]       left_q;
  logic                  rd_vld_q, rd_zero_q;
  logic                  rd_en;
  logic signed [T2W-1:0] t2;
  logic                  rd_att;
  logic                  decided, decision;
  logic signed [T2W-1:0] c2, w2;

  assign wr_idx  = (head_q == LastIdx) ? '0 : head_q + 1'b1;
  assign hist_we = cmd_i.load && (in_type == REQ_MODE);
  assign rd_en   = cmd_i.walk_step && (left_q != '0);

  always_ff @(posedge clk_i) begin
    if (hist_we) begin
      mem[wr_idx] <= {in_mode_att, in_mode_time};
    end
    if (rd_en) begin
      rd_data_q <= mem[ptr_q];
    end
  end

  assign c2 = $signed({2'b00, in_center, 1'b0});
  assign w2 = $signed({(T2W - WidthW)'(0), in_width});
  assign t2 = rd_zero_q ? '0 : $signed({2'b00, rd_data_q[TimeW-1:0], 1'b0});
  assign rd_att = rd_zero_q ? 1'b0 : rd_data_q[TimeW];

  always_comb begin
    decided  = 1'b0;
    decision = 1'b1;
    if (rd_vld_q && (t2 < end2_q)) begin
      if (!rd_att) begin
        decided  = 1'b1;
        decision = 1'b0;
      end else if (t2 <= start2_q) begin
        decided = 1'b1;
      end
    end
  end

  assign sts_o.walk_done = cmd_i.walk_step && (decided || (!rd_vld_q && left_q == '0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      cnt_q     <= CntW'(1);
      e0_wr_q   <= 1'b0;
      ptr_q     <= '0;
      left_q    <= '0;
      rd_vld_q  <= 1'b0;
      rd_zero_q <= 1'b0;
    end else begin
      if (hist_we) begin
        head_q <= wr_idx;
        if (cnt_q < FullCnt) begin
          cnt_q <= cnt_q + 1'b1;
        end
        if (wr_idx == '0) begin
          e0_wr_q <= 1'b1;
        end
      end
      if (cmd_i.load && in_type == REQ_REPORT) begin
        ptr_q    <= head_q;
        left_q   <= cnt_q;
        rd_vld_q <= 1'b0;
      end else if (cmd_i.walk_step) begin
        rd_vld_q <= rd_en;
        if (rd_en) begin
          rd_zero_q <= (ptr_q == '0) && !e0_wr_q;
          ptr_q     <= (ptr_q == '0) ? LastIdx : ptr_q - 1'b1;
          left_q    <= left_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && in_type == REQ_REPORT) begin
      start2_q <= c2 - w2;
      end2_q   <= c2 + w2;
    end
  end

  // checks
  tsi_result_t res, out_q;
  logic        hv_after;
  logic signed [PowerW+1:0] unatt, rel_lim;

  assign unatt   = $signed({{2{power_q[PowerW-1]}}, power_q}) + $signed({4'b0000, sw_att_q});
  assign rel_lim = $signed({{2{thr_q[PowerW-1]}}, thr_q}) - $signed({4'b0000, rel_q});

  always_comb begin
    res               = '0;
    res.status_code   = ST_ALLOWED;
    hv_after          = hv_q;
    if (!src_q[0])      res.status_code = ST_SRC_IO;
    else if (!src_q[1]) res.status_code = ST_SRC_NAV;
    else if (!src_q[2]) res.status_code = ST_SRC_TERRAIN;
    else if (!src_q[3]) res.status_code = ST_SRC_MOTION;
    else if (!src_q[4]) res.status_code = ST_SRC_PWRSRV;
    else if (!fil_q)    res.status_code = ST_FILAMENT;
    else if (!homed_q)  res.status_code = ST_HOMING;
    else if (press_q < min_press_q) res.status_code = ST_PRESSURE;
    else if (hv_q && (power_q > thr_q) && !(avail_q && !rep_att_q)) begin
      res.status_code   = ST_POWER;
      hv_after          = 1'b0;
      res.hv_forced_off = 1'b1;
    end else begin
      if (hv_q && (power_q > thr_q)) begin
        res.status_code = ST_ATTENUATE;
      end
      if ((last_q == ST_ATTENUATE) && (unatt > rel_lim)) begin
        res.status_code = ST_ATTENUATE;
      end
      if ((res.status_code == ST_ATTENUATE) && !avail_q) begin
        res.status_code = ST_NO_ATTEN;
      end
    end
    res.hv_enable      = hv_after && ((res.status_code == ST_ALLOWED) ||
                                      (res.status_code == ST_ATTENUATE));
    res.use_attenuated = (res.status_code == ST_ATTENUATE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hv_q      <= 1'b0;
      last_q    <= ST_UNSET;
      src_q     <= '0;
      fil_q     <= 1'b0;
      homed_q   <= 1'b0;
      avail_q   <= 1'b0;
      press_q   <= '0;
      power_q   <= -12'sd2000;
      rep_att_q <= 1'b0;
    end else begin
      if (cmd_i.load && in_type != REQ_MODE) begin
        src_q <= in_src;
        unique case (in_type)
          REQ_HV:     hv_q    <= in_hv;
          REQ_REPORT: power_q <= in_power;
          REQ_HEALTH: begin
            fil_q   <= in_fil;
            homed_q <= in_homed;
            avail_q <= in_avail;
            press_q <= in_press;
          end
          default: ;
        endcase
      end
      if (sts_o.walk_done) begin
        rep_att_q <= decided ? decision : 1'b1;
      end
      if (cmd_i.commit) begin
        hv_q   <= hv_after;
        last_q <= res.status_code;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_q <= res;
    end
  end

  assign m_axis_tdata_o = {1'b0, out_q};

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) && (cnt_q <= FullCnt))
    else $error("history count out of range");
  a_left_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    left_q <= cnt_q)
    else $error("walk runs past history count");
  a_forced_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && res.hv_forced_off) |=> !hv_q)
    else $error("forced off left hv request set");
`endif

endmodule

@@ hw/rtl/transmit_safety_interlock_unit.sv @@
`timescale 1ns / 1ps
// hv request and health events go to the eval state, which commits the result to
// the output register once it is free; power report: history walk newest-first,
// one ring entry per cycle through the registered memory read port, then eval
// mode change events give no result; one event is in work at a time
// reset: async active low, config to defaults, history holds one unattenuated entry
// at time 0, status unset
// ----------------------------------------------------------------------------
// transmit_safety_interlock_unit
// radar transmitter interlock: hv request, mode history, power and health checks
// ----------------------------------------------------------------------------
module transmit_safety_interlock_unit #(
  parameter int unsigned HISTORY_DEPTH = tsi_pkg::HistDepthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tsi_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tsi_pkg::CfgW-1:0]     cfg_wdata_i,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // hv_request, mode_time, mode_is_attenuated, report_center, dwell_width,
  // mean_power, sources_ok, filament_on, drives_homed, vessel_pressure,
  // atten_available, zero pad
  input  logic [tsi_pkg::InDataW-1:0]  s_axis_tdata_i,
  // req_type
  input  logic [1:0]                   s_axis_tuser_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // status_code, hv_enable, use_attenuated, hv_forced_off, zero pad
  output logic [tsi_pkg::OutDataW-1:0] m_axis_tdata_o
);
  import tsi_pkg::*;

  tsi_cmd_t cmd;
  tsi_sts_t sts;

  tsi_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .cmd_o           (cmd),
    .sts_i           (sts)
  );

  tsi_dp #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .cmd_i          (cmd),
    .sts_o          (sts)
  );

endmodule

@@ tb/transmit_safety_interlock_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// transmit_safety_interlock_unit_tb
// self-checking bench for the transmit interlock: a cycle-free predictor keeps
// its own copy of the hv request, health snapshot, power report and mode ring,
// works out the status of each event as it is accepted and compares every
// result transfer against it; directed cases first, then mostly well-formed
// random event streams under several register settings and stall patterns
// ----------------------------------------------------------------------------
module transmit_safety_interlock_unit_tb;
  import tsi_pkg::*;

  localparam int HistDepth    = HistDepthDef;
  localparam int SettleCycles = 80;
  localparam int QuietLimit   = 5000;

  typedef struct {
    req_type_e                kind;
    logic                     hv;
    logic [TimeW-1:0]         mode_time;
    logic                     mode_att;
    logic [TimeW-1:0]         center;
    logic [WidthW-1:0]        width;
    logic signed [PowerW-1:0] power;
    logic [SrcW-1:0]          src;
    logic                     filament;
    logic                     homed;
    logic [PressW-1:0]        pressure;
    logic                     avail;
  } tsi_item_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgW-1:0]     cfg_wdata;
  logic                s_valid;
  logic [InDataW-1:0]  s_data;
  logic [1:0]          s_user;
  logic                m_ready;
  logic                s_axis_tready_o;
  logic                m_axis_tvalid_o;
  logic [OutDataW-1:0] m_axis_tdata_o;

  // register copies
  logic signed [PowerW-1:0] thr_reg;
  logic [AttW-1:0]          sw_att_reg;
  logic [AttW-1:0]          release_reg;
  logic [PressW-1:0]        min_press_reg;

  // interlock state copies
  logic                     hv_armed;
  status_e                  prev_status;
  logic [7:0]               health_vec;
  logic [PressW-1:0]        vessel_press;
  logic signed [PowerW-1:0] rx_power;
  logic                     dwell_quiet;
  logic [TimeW-1:0]         ring_stamp [HistDepth];
  logic                     ring_att [HistDepth];
  int                       ring_fill;
  int                       ring_top;

  tsi_result_t pending_verdicts[$];
  int          mismatch_cnt;
  int          src_idle_pct;
  int          sink_stall_pct;
  int          hold_req;
  int          hold_left;
  longint      time_cursor;

  transmit_safety_interlock_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit predict_interlock(input tsi_item_t it, output tsi_result_t res);
    status_e st;
    logic    forced;
    logic    prov;
    int      idx;
    int      unatt;
    longint  c2;
    longint  s2;
    longint  e2;
    longint  t2;
    res = '0;
    if (it.kind == REQ_MODE) begin
      ring_top = (ring_top + 1) % HistDepth;
      ring_stamp[ring_top] = it.mode_time;
      ring_att[ring_top] = it.mode_att;
      if (ring_fill < HistDepth) ring_fill++;
      return 1'b0;
    end
    health_vec[4:0] = it.src;
    case (it.kind)
      REQ_HV: begin
        hv_armed = it.hv;
      end
      REQ_REPORT: begin
        rx_power = it.power;
        c2 = longint'(it.center) * 2;
        s2 = c2 - longint'(it.width);
        e2 = c2 + longint'(it.width);
        // unknown history counts as attenuated
        dwell_quiet = 1'b1;
        for (int i = 0; i < ring_fill; i++) begin
          idx = (ring_top + HistDepth - i) % HistDepth;
          t2 = longint'(ring_stamp[idx]) * 2;
          if (t2 < e2) begin
            if (!ring_att[idx]) begin
              dwell_quiet = 1'b0;
              break;
            end
            if (t2 <= s2) break;
          end
        end
      end
      default: begin
        health_vec[7:5] = {it.avail, it.homed, it.filament};
        vessel_press = it.pressure;
      end
    endcase

    st = ST_ALLOWED;
    forced = 1'b0;
    prov = 1'b0;
    if (health_vec[4:0] != '1) begin
      for (int b = 4; b >= 0; b--)
        if (!health_vec[b]) st = status_e'(4'(int'(ST_SRC_IO) + b));
    end else if (!health_vec[5]) begin
      st = ST_FILAMENT;
    end else if (!health_vec[6]) begin
      st = ST_HOMING;
    end else if (vessel_press < min_press_reg) begin
      st = ST_PRESSURE;
    end else begin
      if (hv_armed && rx_power > thr_reg) begin
        if (health_vec[7] && !dwell_quiet) begin
          prov = 1'b1;
        end else begin
          hv_armed = 1'b0;
          forced = 1'b1;
          st = ST_POWER;
        end
      end
      if (st != ST_POWER) begin
        // hysteresis on the way out of attenuation
        unatt = int'(rx_power) + int'(sw_att_reg);
        if (prev_status == ST_ATTENUATE && unatt > int'(thr_reg) - int'(release_reg))
          prov = 1'b1;
        if (prov) st = ST_ATTENUATE;
      end
    end
    if (st == ST_ATTENUATE && !health_vec[7]) st = ST_NO_ATTEN;
    prev_status = st;

    res.status_code    = st;
    res.hv_enable      = hv_armed && (st == ST_ALLOWED || st == ST_ATTENUATE);
    res.use_attenuated = (st == ST_ATTENUATE);
    res.hv_forced_off  = forced;
    return 1'b1;
  endfunction

  function automatic tsi_item_t random_item(req_type_e kind);
    tsi_item_t it;
    it.kind      = kind;
    it.hv        = 1'($urandom_range(1));
    it.mode_time = 48'({$urandom(), $urandom()});
    it.mode_att  = 1'($urandom_range(1));
    it.center    = 48'({$urandom(), $urandom()});
    it.width     = 24'($urandom_range(24'hFFFFFF));
    it.power     = 12'(int'($urandom_range(2500)) - 2000);
    it.src       = 5'($urandom_range(31));
    it.filament  = 1'($urandom_range(1));
    it.homed     = 1'($urandom_range(1));
    it.pressure  = 15'($urandom_range(20000));
    it.avail     = 1'($urandom_range(1));
    return it;
  endfunction

  function automatic tsi_item_t mk_hv(logic hv, logic [SrcW-1:0] src);
    tsi_item_t it;
    it = random_item(REQ_HV);
    it.hv  = hv;
    it.src = src;
    return it;
  endfunction

  function automatic tsi_item_t mk_mode(logic [TimeW-1:0] t, logic att);
    tsi_item_t it;
    it = random_item(REQ_MODE);
    it.mode_time = t;
    it.mode_att  = att;
    return it;
  endfunction

  function automatic tsi_item_t mk_report(logic [TimeW-1:0] c, logic [WidthW-1:0] w,
                                          logic signed [PowerW-1:0] p);
    tsi_item_t it;
    it = random_item(REQ_REPORT);
    it.center = c;
    it.width  = w;
    it.power  = p;
    it.src    = '1;
    return it;
  endfunction

  function automatic tsi_item_t mk_health(logic [SrcW-1:0] src, logic fil, logic homed,
                                          logic [PressW-1:0] press, logic avail);
    tsi_item_t it;
    it = random_item(REQ_HEALTH);
    it.src      = src;
    it.filament = fil;
    it.homed    = homed;
    it.pressure = press;
    it.avail    = avail;
    return it;
  endfunction

  task automatic send_item(input tsi_item_t it);
    tsi_result_t res;
    while (int'($urandom_range(99)) < src_idle_pct) begin
      @(negedge clk_i);
      s_valid <= 1'b0;
    end
    @(negedge clk_i);
    s_valid <= 1'b1;
    s_user  <= it.kind;
    s_data  <= {3'b000, it.avail, it.pressure, it.homed, it.filament, it.src, it.power,
                it.width, it.center, it.mode_att, it.mode_time, it.hv};
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (predict_interlock(it, res)) pending_verdicts.push_back(res);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    s_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    // a mode change may still be in work with nothing expected
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgW-1:0] v);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= v;
    case (idx)
      CFG_THRESHOLD:  thr_reg = v[PowerW-1:0];
      CFG_SWITCH_ATT: sw_att_reg = v[AttW-1:0];
      CFG_RELEASE:    release_reg = v[AttW-1:0];
      default:        min_press_reg = v[PressW-1:0];
    endcase
  endtask

  task automatic apply_setting(int thr, int sw_att, int rel, int min_press);
    wait_idle();
    write_reg(CFG_THRESHOLD, 15'(thr));
    write_reg(CFG_SWITCH_ATT, 15'(sw_att));
    write_reg(CFG_RELEASE, 15'(rel));
    write_reg(CFG_MIN_PRESS, 15'(min_press));
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic test_directed();
    apply_setting(-300, 0, 60, 1000);
    send_item(mk_hv(1'b1, 5'h00));
    for (int b = 0; b < SrcW; b++) send_item(mk_hv(1'b1, 5'h1f ^ 5'(1 << b)));
    send_item(mk_health(5'h1f, 1'b0, 1'b1, 15'd20000, 1'b1));
    send_item(mk_health(5'h1f, 1'b1, 1'b0, 15'd20000, 1'b1));
    send_item(mk_health(5'h1f, 1'b1, 1'b1, 15'd0, 1'b1));
    send_item(mk_health(5'h1f, 1'b1, 1'b1, 15'd20000, 1'b1));
    send_item(mk_mode(48'd1000, 1'b0));
    // mode entry exactly at the dwell end is skipped
    send_item(mk_report(48'd1000, 24'd0, 12'sd500));
    send_item(mk_report(48'd1000, 24'd0, -12'sd350));
    send_item(mk_report(48'd1000, 24'd0, -12'sd370));
    // attenuated entry exactly at the dwell start
    send_item(mk_mode(48'd2000, 1'b1));
    send_item(mk_report(48'd2500, 24'd1000, 12'sd500));
    send_item(mk_report(48'd1500, 24'd0, 12'sd500));
    send_item(mk_hv(1'b1, 5'h1f));
    send_item(mk_hv(1'b0, 5'h1f));
    send_item(mk_health(5'h1f, 1'b1, 1'b1, 15'd20000, 1'b0));
    send_item(mk_mode('1, 1'b1));
    send_item(mk_report('1, '1, -12'sd2000));
    // whole dwell before any known history
    send_item(mk_report(48'd0, 24'd0, 12'sd500));
    send_item(mk_hv(1'b1, 5'h1f));
  endtask

  task automatic test_history_wrap();
    longint base;
    base = 64'd10_000_000;
    send_item(mk_health(5'h1f, 1'b1, 1'b1, 15'd20000, 1'b1));
    send_item(mk_hv(1'b1, 5'h1f));
    for (int k = 0; k < HistDepth + 6; k++) send_item(mk_mode(48'(base + 100 * k), 1'b1));
    send_item(mk_report(48'(base - 50), 24'd10, 12'sd500));
    send_item(mk_report(48'(base + 100 * (HistDepth + 6)), 24'd20, 12'sd500));
    send_item(mk_mode(48'(base + 100 * (HistDepth + 8)), 1'b0));
    send_item(mk_hv(1'b1, 5'h1f));
    send_item(mk_report(48'(base + 100 * (HistDepth + 9)), 24'd40, 12'sd500));
  endtask

  task automatic test_random_events(int n);
    tsi_item_t it;
    int        r;
    int        span;
    int        pw;
    repeat (n) begin
      r = int'($urandom_range(99));
      if (r < 12) begin
        it = random_item(REQ_HEALTH);
        if ($urandom_range(9) != 0) begin
          it.src      = '1;
          it.filament = 1'b1;
          it.homed    = 1'b1;
          it.pressure = 15'($urandom_range(20000, min_press_reg));
          it.avail    = ($urandom_range(4) != 0);
        end
      end else if (r < 24) begin
        it = random_item(REQ_HV);
        it.hv = ($urandom_range(4) != 0);
        if ($urandom_range(9) != 0) it.src = '1;
      end else if (r < 55) begin
        it = random_item(REQ_MODE);
        if ($urandom_range(9) != 0) begin
          time_cursor += longint'($urandom_range(3000, 1));
          it.mode_time = 48'(time_cursor);
        end
      end else begin
        it = random_item(REQ_REPORT);
        if ($urandom_range(9) != 0) begin
          it.src    = '1;
          it.center = 48'(time_cursor - longint'($urandom_range(4000)));
          it.width  = 24'($urandom_range(6000));
          span = int'(sw_att_reg) + int'(release_reg) + 200;
          pw = int'(thr_reg) - span + int'($urandom_range(2 * span));
          if (pw > 500) pw = 500;
          if (pw < -2000) pw = -2000;
          it.power = 12'(pw);
        end
      end
      send_item(it);
    end
  endtask

  task automatic test_backpressure();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_req = 500;
    test_random_events(30);
  endtask

  // result side: stalls and long hold-off
  always @(negedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_ready <= 1'b0;
    end else begin
      m_ready <= !(int'($urandom_range(99)) < sink_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    tsi_result_t got;
    tsi_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      got = tsi_result_t'(m_axis_tdata_o[6:0]);
      if (pending_verdicts.size() == 0) begin
        $error("result transfer with nothing expected: status_code %0d", got.status_code);
        mismatch_cnt++;
      end else begin
        want = pending_verdicts.pop_front();
        if (got.status_code != want.status_code) begin
          $error("status_code expected %0d got %0d", want.status_code, got.status_code);
          mismatch_cnt++;
        end
        if (got.hv_enable != want.hv_enable) begin
          $error("hv_enable expected %0d got %0d", want.hv_enable, got.hv_enable);
          mismatch_cnt++;
        end
        if (got.use_attenuated != want.use_attenuated) begin
          $error("use_attenuated expected %0d got %0d", want.use_attenuated,
                 got.use_attenuated);
          mismatch_cnt++;
        end
        if (got.hv_forced_off != want.hv_forced_off) begin
          $error("hv_forced_off expected %0d got %0d", want.hv_forced_off,
                 got.hv_forced_off);
          mismatch_cnt++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_ready)) quiet = 0;
      else quiet++;
    end
    $display("transmit_safety_interlock_unit verification failed");
    $finish;
  end

  initial begin
    rst_ni         = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = CFG_THRESHOLD;
    cfg_wdata      = '0;
    s_valid        = 1'b0;
    s_data         = '0;
    s_user         = REQ_HV;
    m_ready        = 1'b0;
    mismatch_cnt   = 0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_req       = 0;
    hold_left      = 0;
    time_cursor    = 64'd100_000_000;
    thr_reg        = -12'sd300;
    sw_att_reg     = '0;
    release_reg    = 10'd60;
    min_press_reg  = '0;
    hv_armed       = 1'b0;
    prev_status    = ST_UNSET;
    health_vec     = '0;
    vessel_press   = '0;
    rx_power       = -12'sd2000;
    dwell_quiet    = 1'b0;
    ring_stamp[0]  = '0;
    ring_att[0]    = 1'b0;
    ring_fill      = 1;
    ring_top       = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_history_wrap();

    apply_setting(-2000, 0, 0, 0);
    test_random_events(125);

    apply_setting(500, 600, 600, 20000);
    src_idle_pct = 85;
    test_random_events(125);

    apply_setting(int'($urandom_range(2500)) - 2000, int'($urandom_range(600)),
                  int'($urandom_range(600)), int'($urandom_range(20000)));
    src_idle_pct   = 0;
    sink_stall_pct = 85;
    test_random_events(125);

    apply_setting(-500, 300, 60, 10000);
    src_idle_pct   = 19;
    sink_stall_pct = 19;
    test_random_events(125);

    test_backpressure();
    wait_idle();

    if (mismatch_cnt == 0) begin
      $display("transmit_safety_interlock_unit verification clean");
    end else begin
      $display("transmit_safety_interlock_unit verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/tsi_pkg.sv
hw/rtl/tsi_ctrl.sv
hw/rtl/tsi_dp.sv
hw/rtl/transmit_safety_interlock_unit.sv
tb/transmit_safety_interlock_unit_tb.sv
